>>> sv/audio_trim_point_aligner_macros.svh
// Assertion macros shared by the trim point aligner modules.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef AUDIO_TRIM_POINT_ALIGNER_MACROS_SVH
`define AUDIO_TRIM_POINT_ALIGNER_MACROS_SVH
// same-cycle implication
`define ATPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ATPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> sv/atpa_pkg.sv
// Package for the audio trim point aligner: constants, codes, command and
// status structs and the 24-bit saturation helper. No dependencies.
`default_nettype none
package atpa_pkg;

  // field and divider widths
  localparam int DIV_W      = 42;
  localparam int DSR_W      = 23;
  localparam int DIV_STEPS  = 3;

  // arithmetic constants
  localparam int FRAME_DIV   = 4800;
  localparam int NTSC_MUL    = 1001;
  localparam int PAL_MUL     = 24;
  localparam int TICKS_NTSC  = 3003;
  localparam int TICKS_PAL   = 3600;
  localparam int TICKS_FRAME = 150;
  localparam int SAT24       = 8388607;

  // trim kinds
  localparam logic [1:0] KIND_SEAMLESS = 2'd0;
  localparam logic [1:0] KIND_PADDED   = 2'd1;
  localparam logic [1:0] KIND_DISCRETE = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  // shift modes; the spare code behaves as forward
  localparam logic [1:0] SHIFT_FWD   = 2'd0;
  localparam logic [1:0] SHIFT_BACK  = 2'd1;
  localparam logic [1:0] SHIFT_NEAR  = 2'd2;
  localparam logic [1:0] SHIFT_SPARE = 2'd3;

  // divider operand selects
  localparam logic [1:0] DSEL_UNIT  = 2'd0;
  localparam logic [1:0] DSEL_ROUND = 2'd1;
  localparam logic [1:0] DSEL_FRAME = 2'd2;
  localparam logic [1:0] DSEL_VIDEO = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       div_start;
    logic [1:0] div_sel;
    logic       unit_upd;
    logic       prep_upd;
    logic       rnd_upd;
    logic       cry_upd;
    logic       pad_upd;
    logic       frm_upd;
    logic       vid_upd;
    logic       out_load;
  } atpa_cmd_t;

  typedef struct packed {
    logic new_title;
    logic div_done;
    logic out_free;
  } atpa_sts_t;

  // clamp to +/- 8388607
  function automatic logic signed [23:0] sat24(input logic signed [42:0] v);
    logic signed [23:0] r;
    if (v > 43'(SAT24)) begin
      r = 24'(SAT24);
    end else if (v < -43'(SAT24)) begin
      r = -24'(SAT24);
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/atpa_div.sv
// Restoring divider, several quotient bits per cycle, registered results.
// Depends on atpa_pkg for the dividend and divisor widths.
`default_nettype none
module atpa_div #(
  parameter int STEPS = atpa_pkg::DIV_STEPS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [atpa_pkg::DIV_W-1:0]  dividend,
  input  wire logic [atpa_pkg::DSR_W-1:0]  divisor,
  output logic                             done,
  output logic [atpa_pkg::DIV_W-1:0]       quot,
  output logic [atpa_pkg::DSR_W-1:0]       rem
);

  localparam int DW    = atpa_pkg::DIV_W;
  localparam int RW    = atpa_pkg::DSR_W;
  localparam int ITERS = (DW + STEPS - 1) / STEPS;
  localparam int QW    = ITERS * STEPS;
  localparam int CW    = $clog2(ITERS + 1);

  logic [QW-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  // STEPS restoring steps per cycle
  always_comb begin
    logic [RW:0] t;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    t       = '0;
    for (int i = 0; i < STEPS; i++) begin
      t     = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t        = t - {1'b0, dsr_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = t[RW-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= QW'(dividend);
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r[DW-1:0];
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> sv/atpa_ctrl.sv
// Sequencing state machine for the trim point aligner.
// Depends on atpa_pkg (command/status structs, divider selects).
`default_nettype none
`include "audio_trim_point_aligner_macros.svh"
module atpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire atpa_pkg::atpa_sts_t sts,
  output atpa_pkg::atpa_cmd_t      cmd
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHK    = 5'd1;
  localparam logic [4:0] S_U_GO   = 5'd2;
  localparam logic [4:0] S_U_WAIT = 5'd3;
  localparam logic [4:0] S_U_SET  = 5'd4;
  localparam logic [4:0] S_PREP   = 5'd5;
  localparam logic [4:0] S_R_GO   = 5'd6;
  localparam logic [4:0] S_R_WAIT = 5'd7;
  localparam logic [4:0] S_R_SET  = 5'd8;
  localparam logic [4:0] S_C_SET  = 5'd9;
  localparam logic [4:0] S_P_SET  = 5'd10;
  localparam logic [4:0] S_F_GO   = 5'd11;
  localparam logic [4:0] S_F_WAIT = 5'd12;
  localparam logic [4:0] S_F_SET  = 5'd13;
  localparam logic [4:0] S_V_GO   = 5'd14;
  localparam logic [4:0] S_V_WAIT = 5'd15;
  localparam logic [4:0] S_V_SET  = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;

  logic [4:0] state_r, state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK:    state_nxt = sts.new_title ? S_U_GO : S_PREP;
      S_U_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atpa_pkg::DSEL_UNIT;
        state_nxt     = S_U_WAIT;
      end
      S_U_WAIT: if (sts.div_done) state_nxt = S_U_SET;
      S_U_SET: begin
        cmd.unit_upd = 1'b1;
        state_nxt    = S_PREP;
      end
      S_PREP: begin
        cmd.prep_upd = 1'b1;
        state_nxt    = S_R_GO;
      end
      S_R_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atpa_pkg::DSEL_ROUND;
        state_nxt     = S_R_WAIT;
      end
      S_R_WAIT: if (sts.div_done) state_nxt = S_R_SET;
      S_R_SET: begin
        cmd.rnd_upd = 1'b1;
        state_nxt   = S_C_SET;
      end
      S_C_SET: begin
        cmd.cry_upd = 1'b1;
        state_nxt   = S_P_SET;
      end
      S_P_SET: begin
        cmd.pad_upd = 1'b1;
        state_nxt   = S_F_GO;
      end
      S_F_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atpa_pkg::DSEL_FRAME;
        state_nxt     = S_F_WAIT;
      end
      S_F_WAIT: if (sts.div_done) state_nxt = S_F_SET;
      S_F_SET: begin
        cmd.frm_upd = 1'b1;
        state_nxt   = S_V_GO;
      end
      S_V_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = atpa_pkg::DSEL_VIDEO;
        state_nxt     = S_V_WAIT;
      end
      S_V_WAIT: if (sts.div_done) state_nxt = S_V_SET;
      S_V_SET: begin
        cmd.vid_upd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ATPA_ASSERT_NXT(a_load_returns_idle, cmd.out_load, state_r == S_IDLE, "no return to idle")
  `ATPA_ASSERT_NXT(a_div_not_instant, cmd.div_start, !sts.div_done, "divider done too early")
  `ATPA_ASSERT_NXT(a_capture_checks, cmd.capture, state_r == S_CHK && !in_ready, "bad accept")

endmodule
`default_nettype wire

>>> sv/atpa_dp.sv
// Datapath of the trim point aligner: title state, carry, totals, output
// register and the shared divider. Depends on atpa_pkg and atpa_div.
`default_nettype none
`include "audio_trim_point_aligner_macros.svh"
module atpa_dp #(
  parameter int DIV_STEPS = atpa_pkg::DIV_STEPS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire atpa_pkg::atpa_cmd_t cmd,
  output atpa_pkg::atpa_sts_t      sts,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_data,
  input  wire logic [39:0]         in_audio_bytes,
  input  wire logic [7:0]          in_title_group,
  input  wire logic [17:0]         in_sample_rate,
  input  wire logic [3:0]          in_channel_count,
  input  wire logic [4:0]          in_sample_bits,
  input  wire logic [1:0]          in_trim_kind,
  input  wire logic [1:0]          in_shift_mode,
  input  wire logic                in_sequence_start,
  input  wire logic                in_sequence_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [22:0]              out_trim_unit,
  output logic signed [23:0]       out_trim_offset,
  output logic [40:0]              out_trim_length,
  output logic [33:0]              out_audio_frame_count,
  output logic [12:0]              out_audio_loss,
  output logic [31:0]              out_video_frame_count,
  output logic [11:0]              out_audio_gap,
  output logic signed [23:0]       out_audio_padding,
  output logic                     out_title_start,
  output logic                     out_appended,
  output logic [31:0]              out_title_frame_start,
  output logic [47:0]              out_total_audio_bytes
);

  localparam int DW = atpa_pkg::DIV_W;
  localparam int RW = atpa_pkg::DSR_W;

  // configuration and persistent state
  logic               ntsc_r;
  logic [8:0]         cur_title_r;
  logic signed [23:0] carry_r;
  logic [31:0]        tfc_r;
  logic [7:0]         ssu_r;
  logic [12:0]        afu_r;
  logic [22:0]        avu_r;
  logic [47:0]        total_r;
  logic               out_valid_r;

  // item registers
  logic [39:0]        abytes_r;
  logic [7:0]         group_r;
  logic [17:0]        rate_r;
  logic [8:0]         chbits_r;
  logic [1:0]         kind_r;
  logic [1:0]         shift_r;
  logic               sstart_r;
  logic               send_r;
  logic               tstart_r;

  // working registers
  logic [22:0]        unit_r;
  logic               disc_r;
  logic               app_r;
  logic signed [41:0] x_r;
  logic signed [23:0] offset_r;
  logic [40:0]        len_r;
  logic signed [23:0] pad_r;
  logic [33:0]        frames_r;
  logic [12:0]        loss_r;
  logic [31:0]        vfr_r;
  logic [11:0]        gap_r;

  // divider
  logic [DW-1:0] dvd;
  logic [RW-1:0] dsr;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [RW-1:0] div_rem;

  logic [26:0]   prod27;
  logic [11:0]   vpt;
  logic [9:0]    av_mul;

  assign prod27 = {9'b0, rate_r} * {18'b0, chbits_r};
  assign vpt    = ntsc_r ? 12'(atpa_pkg::TICKS_NTSC) : 12'(atpa_pkg::TICKS_PAL);
  assign av_mul = ntsc_r ? 10'(atpa_pkg::NTSC_MUL) : 10'(atpa_pkg::PAL_MUL);

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      atpa_pkg::DSEL_UNIT: begin
        dvd = DW'(prod27);
        dsr = RW'(atpa_pkg::FRAME_DIV);
      end
      atpa_pkg::DSEL_ROUND: begin
        dvd = x_r[DW-1:0];
        dsr = unit_r;
      end
      atpa_pkg::DSEL_FRAME: begin
        dvd = {1'b0, len_r};
        dsr = {10'b0, afu_r};
      end
      atpa_pkg::DSEL_VIDEO: begin
        dvd = {8'b0, frames_r} * DW'(atpa_pkg::TICKS_FRAME);
        dsr = {11'b0, vpt};
      end
      default: begin
        dvd = DW'(prod27);
        dsr = RW'(atpa_pkg::FRAME_DIV);
      end
    endcase
  end

  atpa_div #(.STEPS(DIV_STEPS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // rounding of the length up to the unit
  logic        xpos;
  logic [40:0] len_round;
  assign xpos = !x_r[41] && (x_r != '0);
  always_comb begin
    if (!xpos) begin
      len_round = '0;
    end else if (unit_r == '0 || div_rem == '0) begin
      len_round = x_r[40:0];
    end else begin
      len_round = x_r[40:0] + {18'b0, unit_r} - {18'b0, div_rem};
    end
  end

  // carry and optional backward shift
  logic signed [42:0] neg43;
  logic [25:0]        neg26;
  logic               shift_go;
  logic signed [25:0] carry_f;
  logic               len_shift;
  assign neg43 = $signed({2'b00, len_r}) - $signed({x_r[41], x_r});
  assign neg26 = neg43[25:0];
  assign shift_go = (shift_r == atpa_pkg::SHIFT_BACK) ||
                    ((shift_r == atpa_pkg::SHIFT_NEAR) && (neg26 > {4'b0, unit_r[22:1]}));
  always_comb begin
    len_shift = 1'b0;
    if (disc_r) begin
      carry_f = '0;
    end else if (len_r != {1'b0, abytes_r}) begin
      carry_f = -$signed(neg26);
      if (shift_go && (len_r >= {18'b0, unit_r})) begin
        len_shift = 1'b1;
        carry_f   = carry_f + $signed({3'b0, unit_r});
      end
    end else begin
      carry_f = {{2{carry_r[23]}}, carry_r};
    end
  end

  logic signed [42:0] pad43;
  assign pad43 = $signed({2'b00, len_r}) - $signed({x_r[41], x_r});

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntsc_r <= 1'b0;
    end else if (cfg_valid) begin
      ntsc_r <= cfg_data;
    end
  end

  // persistent state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_title_r <= 9'h100;
      carry_r     <= '0;
      tfc_r       <= '0;
      ssu_r       <= '0;
      afu_r       <= '0;
      avu_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      tstart_r    <= 1'b0;
    end else begin
      if (cmd.capture) begin
        tstart_r <= 1'b0;
      end
      if (cmd.unit_upd) begin
        ssu_r       <= 8'(chbits_r >> 2);
        afu_r       <= div_quot[12:0];
        avu_r       <= {10'b0, div_quot[12:0]} * {13'b0, av_mul};
        cur_title_r <= {1'b0, group_r};
        tfc_r       <= '0;
        carry_r     <= '0;
        tstart_r    <= 1'b1;
      end
      if (cmd.cry_upd) begin
        carry_r <= atpa_pkg::sat24({{17{carry_f[25]}}, carry_f});
      end
      if (cmd.frm_upd) begin
        total_r <= total_r + {7'b0, len_r} + {{24{pad_r[23]}}, pad_r};
      end
      if (cmd.out_load) begin
        tfc_r       <= tfc_r + vfr_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      abytes_r <= in_audio_bytes;
      group_r  <= in_title_group;
      rate_r   <= in_sample_rate;
      chbits_r <= {5'b0, in_channel_count} * {4'b0, in_sample_bits};
      kind_r   <= in_trim_kind;
      shift_r  <= in_shift_mode;
      sstart_r <= in_sequence_start;
      send_r   <= in_sequence_end;
    end
    if (cmd.prep_upd) begin
      if (kind_r == atpa_pkg::KIND_NONE) begin
        unit_r <= {15'b0, ssu_r};
        disc_r <= 1'b1;
      end else if (kind_r == atpa_pkg::KIND_DISCRETE || send_r) begin
        unit_r <= {10'b0, afu_r};
        disc_r <= 1'b1;
      end else begin
        unit_r <= avu_r;
        disc_r <= 1'b0;
      end
      app_r    <= !sstart_r && !kind_r[1];
      x_r      <= $signed({2'b00, abytes_r}) + $signed({{18{carry_r[23]}}, carry_r});
      offset_r <= -carry_r;
    end
    if (cmd.rnd_upd) begin
      len_r <= len_round;
    end
    if (cmd.cry_upd && len_shift) begin
      len_r <= len_r - {18'b0, unit_r};
    end
    if (cmd.pad_upd) begin
      if (kind_r == atpa_pkg::KIND_SEAMLESS && !send_r) begin
        pad_r <= '0;
      end else begin
        pad_r <= atpa_pkg::sat24(pad43);
      end
    end
    if (cmd.frm_upd) begin
      frames_r <= (afu_r == '0) ? '0 : div_quot[33:0];
      loss_r   <= (afu_r == '0) ? '0 : div_rem[12:0];
    end
    if (cmd.vid_upd) begin
      vfr_r <= div_quot[31:0] + {31'b0, (div_rem != '0)};
      gap_r <= (div_rem == '0) ? '0 : vpt - div_rem[11:0];
    end
    if (cmd.out_load) begin
      out_trim_unit         <= unit_r;
      out_trim_offset       <= offset_r;
      out_trim_length       <= len_r;
      out_audio_frame_count <= frames_r;
      out_audio_loss        <= loss_r;
      out_video_frame_count <= vfr_r;
      out_audio_gap         <= gap_r;
      out_audio_padding     <= pad_r;
      out_title_start       <= tstart_r;
      out_appended          <= app_r;
      out_title_frame_start <= tfc_r;
      out_total_audio_bytes <= total_r;
    end
  end

  // status
  assign sts.new_title = ({1'b0, group_r} != cur_title_r);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;

  `ATPA_ASSERT_NXT(a_disc_clears_carry, cmd.cry_upd && disc_r, carry_r == '0, "carry kept")
  `ATPA_ASSERT_NXT(a_title_open, cmd.unit_upd, !cur_title_r[8] && tfc_r == '0, "title not open")
  `ATPA_ASSERT_NXT(a_loss_below_frame, cmd.frm_upd && afu_r != '0, loss_r < afu_r, "loss too big")

endmodule
`default_nettype wire

>>> sv/audio_trim_point_aligner.sv
// Top level of the audio trim point aligner: controller plus datapath.
// Depends on atpa_pkg, atpa_ctrl, atpa_dp (which holds atpa_div).
//
//  channel | ports                      | direction
//  in      | in_valid/in_ready + fields | item in
//  out     | out_valid/out_ready+fields | result out
//  cfg     | cfg_valid/cfg_ready/data   | tv system write
//
// One item at a time. Each item takes three runs of the shared iterative
// divider, and one more when the title group changes; these divider runs
// set how long an item takes.
// Reset is synchronous; state returns to "no title", totals cleared.
// The next item is taken while a result waits in the output register; a
// stalled output only holds the sequencer in its final step.
`default_nettype none
module audio_trim_point_aligner #(
  parameter int DIV_STEPS = atpa_pkg::DIV_STEPS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [39:0]   in_audio_bytes,
  input  wire logic [7:0]    in_title_group,
  input  wire logic [17:0]   in_sample_rate,
  input  wire logic [3:0]    in_channel_count,
  input  wire logic [4:0]    in_sample_bits,
  input  wire logic [1:0]    in_trim_kind,
  input  wire logic [1:0]    in_shift_mode,
  input  wire logic          in_sequence_start,
  input  wire logic          in_sequence_end,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [22:0]        out_trim_unit,
  output logic signed [23:0] out_trim_offset,
  output logic [40:0]        out_trim_length,
  output logic [33:0]        out_audio_frame_count,
  output logic [12:0]        out_audio_loss,
  output logic [31:0]        out_video_frame_count,
  output logic [11:0]        out_audio_gap,
  output logic signed [23:0] out_audio_padding,
  output logic               out_title_start,
  output logic               out_appended,
  output logic [31:0]        out_title_frame_start,
  output logic [47:0]        out_total_audio_bytes
);

  atpa_pkg::atpa_cmd_t cmd;
  atpa_pkg::atpa_sts_t sts;

  // register write is always taken
  assign cfg_ready = 1'b1;

  atpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atpa_dp #(.DIV_STEPS(DIV_STEPS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid),
    .cfg_data              (cfg_data),
    .in_audio_bytes        (in_audio_bytes),
    .in_title_group        (in_title_group),
    .in_sample_rate        (in_sample_rate),
    .in_channel_count      (in_channel_count),
    .in_sample_bits        (in_sample_bits),
    .in_trim_kind          (in_trim_kind),
    .in_shift_mode         (in_shift_mode),
    .in_sequence_start     (in_sequence_start),
    .in_sequence_end       (in_sequence_end),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_trim_unit         (out_trim_unit),
    .out_trim_offset       (out_trim_offset),
    .out_trim_length       (out_trim_length),
    .out_audio_frame_count (out_audio_frame_count),
    .out_audio_loss        (out_audio_loss),
    .out_video_frame_count (out_video_frame_count),
    .out_audio_gap         (out_audio_gap),
    .out_audio_padding     (out_audio_padding),
    .out_title_start       (out_title_start),
    .out_appended          (out_appended),
    .out_title_frame_start (out_title_frame_start),
    .out_total_audio_bytes (out_total_audio_bytes)
  );

endmodule
`default_nettype wire
